@@ hdl/lwsc_pkg.sv @@
// Shared constants for the LRU write-back sector cache controller.
package lwsc_pkg;

    // Request codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_ZERO  = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam int CMD_W    = 2;
    localparam int SECTOR_W = 32;
    localparam int SLOT_W   = 6;

    localparam int NUM_SLOTS_DEF = 64;

endpackage

@@ hdl/lru_writeback_sector_cache.sv @@
// Top level: tag, recency and dirty controller of a fully associative sector cache.
//
// Usage: drive i_cmd and i_sector and raise start while busy is low; the item is
// taken at that clock edge and busy stays high until its last result is out.
// Results appear on the o_ ports for one cycle each, marked by o_strobe; the
// receiver cannot hold them off and must take every strobed cycle.
// A lookup (read, write, write zeroed) gives one result with o_last set.
// It scans the tag memory one slot per cycle (N = slots in use), then walks the
// recency list memory to move the slot to the front, one entry per cycle.
// The walk ends at the slot's old recency position, or covers the whole list for a
// new or evicted slot; an eviction first reads the victim from the list tail and
// then its tag.
// A flush walks the recency list front to back and gives one result per dirty
// slot, the final one with o_last; with nothing dirty it gives a single empty
// result.
// Reset (synchronous, active low) empties the cache and clears all dirty marks;
// the memories are not cleared, only slots in use are ever read.
// busy falls in the same cycle as the final result's strobe.
module lru_writeback_sector_cache #(
    parameter int NUM_SLOTS = lwsc_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lwsc_pkg::CMD_W-1:0]    i_cmd,
    input  logic [lwsc_pkg::SECTOR_W-1:0] i_sector,
    output logic                          o_strobe,
    output logic                          o_hit,
    output logic [lwsc_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_fill_needed,
    output logic                          o_writeback_valid,
    output logic [lwsc_pkg::SECTOR_W-1:0] o_writeback_sector,
    output logic                          o_last
);

    localparam int SW  = $clog2(NUM_SLOTS);
    localparam int CW  = $clog2(NUM_SLOTS + 1);
    localparam int SEW = lwsc_pkg::SECTOR_W;
    localparam int SLW = lwsc_pkg::SLOT_W;
    localparam logic [CW-1:0] FULL = CW'(NUM_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_VRANK, S_VSLOT, S_VTAG, S_SHIFT, S_DONE, S_FLUSH
    } t_state;

    t_state r_state;

    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_idx;
    logic                 r_pend;
    logic [SW-1:0]        r_pidx;
    logic [1:0]           r_cmd;
    logic [SEW-1:0]       r_sector;
    logic [SW-1:0]        r_slot;
    logic [SW-1:0]        r_carry;
    logic                 r_hit;
    logic                 r_new;
    logic                 r_wbv;
    logic [SEW-1:0]       r_wbs;
    logic [NUM_SLOTS-1:0] r_dirty;
    // flush pipeline: tag read stage and one-deep result buffer
    logic                 r_p2;
    logic [SW-1:0]        r_p2slot;
    logic                 r_bufv;
    logic [SW-1:0]        r_bufslot;
    logic [SEW-1:0]       r_bufsec;

    logic           tag_we;
    logic [SW-1:0]  tag_raddr;
    logic [SEW-1:0] tag_rdata;
    logic           ord_we;
    logic [SW-1:0]  ord_waddr;
    logic [SW-1:0]  ord_raddr;
    logic [SW-1:0]  ord_rdata;
    logic           shift_tail;

    assign busy = (r_state != S_IDLE);

    // sector held by each slot
    lwsc_ram #(.WIDTH(SEW), .DEPTH(NUM_SLOTS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_slot),
        .i_wdata (r_sector),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    // recency list: entry r holds the slot at recency position r
    lwsc_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (r_carry),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // for a new slot, the last old entry goes to the new tail once all old entries moved down
    assign shift_tail = (r_state == S_SHIFT) && !r_pend && (r_idx == r_cnt) && r_new;

    // memory addressing
    always_comb begin
        tag_we    = (r_state == S_DONE) && !r_hit;
        tag_raddr = r_idx[SW-1:0];
        ord_raddr = r_idx[SW-1:0];
        ord_we    = 1'b0;
        ord_waddr = r_pidx;
        unique case (r_state)
            S_VRANK: ord_raddr = SW'(r_cnt - CW'(1));
            S_VSLOT: tag_raddr = ord_rdata;
            S_FLUSH: tag_raddr = ord_rdata;
            S_SHIFT: begin
                if (r_pend) begin
                    ord_we = 1'b1;
                end else if (shift_tail) begin
                    ord_we    = 1'b1;
                    ord_waddr = r_cnt[SW-1:0];
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_dirty  <= '0;
            r_pend   <= 1'b0;
            r_p2     <= 1'b0;
            r_bufv   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd    <= i_cmd;
                        r_sector <= i_sector;
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        r_p2     <= 1'b0;
                        r_bufv   <= 1'b0;
                        r_state  <= (i_cmd == lwsc_pkg::CMD_FLUSH) ? S_FLUSH : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pend && tag_rdata == r_sector) begin
                        // hit
                        r_hit   <= 1'b1;
                        r_new   <= 1'b0;
                        r_slot  <= r_pidx;
                        r_carry <= r_pidx;
                        r_wbv   <= 1'b0;
                        r_wbs   <= '0;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SHIFT;
                    end else if (r_idx == r_cnt) begin
                        r_hit  <= 1'b0;
                        r_pend <= 1'b0;
                        if (r_cnt != FULL) begin
                            r_new   <= 1'b1;
                            r_slot  <= r_cnt[SW-1:0];
                            r_carry <= r_cnt[SW-1:0];
                            r_wbv   <= 1'b0;
                            r_wbs   <= '0;
                            r_idx   <= '0;
                            r_state <= S_SHIFT;
                        end else begin
                            r_new   <= 1'b0;
                            r_state <= S_VRANK;
                        end
                    end else begin
                        r_pend <= 1'b1;
                        r_pidx <= r_idx[SW-1:0];
                        r_idx  <= r_idx + CW'(1);
                    end
                end
                S_VRANK: r_state <= S_VSLOT;
                S_VSLOT: begin
                    // least recent slot is the victim
                    r_slot  <= ord_rdata;
                    r_carry <= ord_rdata;
                    r_state <= S_VTAG;
                end
                S_VTAG: begin
                    r_wbv   <= r_dirty[r_slot];
                    r_wbs   <= r_dirty[r_slot] ? tag_rdata : '0;
                    r_idx   <= '0;
                    r_pend  <= 1'b0;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (r_pend && ord_rdata == r_slot) begin
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        if (r_pend) begin
                            r_carry <= ord_rdata;
                        end
                        if (r_idx != r_cnt) begin
                            r_pend <= 1'b1;
                            r_pidx <= r_idx[SW-1:0];
                            r_idx  <= r_idx + CW'(1);
                        end else begin
                            r_pend <= 1'b0;
                            if (!r_pend) begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (r_hit) begin
                        if (r_cmd != lwsc_pkg::CMD_READ) begin
                            r_dirty[r_slot] <= 1'b1;
                        end
                    end else begin
                        r_dirty[r_slot] <= (r_cmd != lwsc_pkg::CMD_READ);
                    end
                    if (r_new) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    o_strobe           <= 1'b1;
                    o_hit              <= r_hit;
                    o_slot             <= SLW'(r_slot);
                    o_fill_needed      <= !r_hit && (r_cmd != lwsc_pkg::CMD_ZERO);
                    o_writeback_valid  <= r_wbv;
                    o_writeback_sector <= r_wbs;
                    o_last             <= 1'b1;
                    r_state            <= S_IDLE;
                end
                S_FLUSH: begin
                    // stage 0: read recency list in order
                    if (r_idx != r_cnt) begin
                        r_pend <= 1'b1;
                        r_idx  <= r_idx + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                    // stage 1: dirty check, tag read issued
                    if (r_pend && r_dirty[ord_rdata]) begin
                        r_p2              <= 1'b1;
                        r_p2slot          <= ord_rdata;
                        r_dirty[ord_rdata] <= 1'b0;
                    end else begin
                        r_p2 <= 1'b0;
                    end
                    // stage 2: hold one item back so the final one carries last
                    if (r_p2) begin
                        if (r_bufv) begin
                            o_strobe           <= 1'b1;
                            o_hit              <= 1'b0;
                            o_slot             <= SLW'(r_bufslot);
                            o_fill_needed      <= 1'b0;
                            o_writeback_valid  <= 1'b1;
                            o_writeback_sector <= r_bufsec;
                            o_last             <= 1'b0;
                        end
                        r_bufv    <= 1'b1;
                        r_bufslot <= r_p2slot;
                        r_bufsec  <= tag_rdata;
                    end
                    if (r_idx == r_cnt && !r_pend && !r_p2) begin
                        o_strobe           <= 1'b1;
                        o_hit              <= 1'b0;
                        o_slot             <= r_bufv ? SLW'(r_bufslot) : '0;
                        o_fill_needed      <= 1'b0;
                        o_writeback_valid  <= r_bufv;
                        o_writeback_sector <= r_bufv ? r_bufsec : '0;
                        o_last             <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // fill count never exceeds the number of slots
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL) else $error("fill count out of range");

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("item accepted but not busy");

    // busy drops only with the final result
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_strobe && o_last)
        else $error("busy dropped without final result");

    // a result without last only comes from a flush
    a_nonlast_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> r_state == S_FLUSH && o_writeback_valid)
        else $error("non-final result outside flush");

    // recency list writes stay inside the slots in use or the next free entry
    a_ord_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ord_we |-> CW'(ord_waddr) <= r_cnt && CW'(ord_waddr) < FULL)
        else $error("recency list write out of range");

endmodule

@@ hdl/lwsc_ram.sv @@
// Simple dual-port memory: one write port, one registered read port.
module lwsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
